// File: src/ggli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ggli_pkg;

    // Number of color channels built by default.
    localparam int NUM_COLORS_DEF = 3;

    // Anchor table size and queue depth between the front and back parts.
    localparam int ANCHOR_COUNT = 9;
    localparam int FIFO_DEPTH   = 2;

    // The segment quotient is found one bit per cycle over the 32-bit difference.
    localparam int DIV_STEPS = 32;

    // Result status codes.
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_ANCHOR_BAD = 2'd1;
    localparam logic [1:0] STATUS_REF_BAD    = 2'd2;

    // One input request.
    typedef struct packed {
        logic [1:0]         color;
        logic [3:0]         anchor_number;
        logic signed [31:0] anchor_voltage;
    } t_in_item;

    // One result.
    typedef struct packed {
        logic [7:0]         gray_level;
        logic [1:0]         out_color;
        logic signed [31:0] level_voltage;
        logic [1:0]         status;
        logic               last;
    } t_out_item;

    // Classified request handed from the front to the back.
    typedef struct packed {
        logic [1:0]         color;
        logic [3:0]         anchor_number;
        logic signed [31:0] low;
        logic [31:0]        diff;
        logic [1:0]         status;
    } t_cmd;

    // Queue fill status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ADV,
        ST_EMIT,
        ST_ERR
    } t_state;

    // Gray level at which an anchor sits.
    function automatic logic [7:0] anchor_last(input logic [3:0] num);
        logic [7:0] g;
        case (num)
            4'd0:    g = 8'd3;
            4'd1:    g = 8'd11;
            4'd2:    g = 8'd23;
            4'd3:    g = 8'd35;
            4'd4:    g = 8'd51;
            4'd5:    g = 8'd87;
            4'd6:    g = 8'd151;
            4'd7:    g = 8'd203;
            4'd8:    g = 8'd255;
            default: g = 8'd0;
        endcase
        return g;
    endfunction

    // Gray level of the previous anchor, zero below the first one.
    function automatic logic [7:0] anchor_first(input logic [3:0] num);
        logic [7:0] g;
        case (num)
            4'd0:    g = 8'd0;
            4'd1:    g = 8'd3;
            4'd2:    g = 8'd11;
            4'd3:    g = 8'd23;
            4'd4:    g = 8'd35;
            4'd5:    g = 8'd51;
            4'd6:    g = 8'd87;
            4'd7:    g = 8'd151;
            4'd8:    g = 8'd203;
            default: g = 8'd0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// File: src/gamma_gray_level_interpolator.sv
// Gray-level voltage interpolator.
// Input channel (i_in_valid / o_in_stall / i_in_item): one anchor voltage per
// request, taken at a clock edge with valid high and stall low. Requests with
// an anchor number above 8 or an unbuilt color are dropped without a result.
// Output channel (o_out_valid / i_out_stall / o_out_result): the gray-level
// voltages of the segment ending at that anchor, in rising gray order, with
// last set on the final one. A request that fails its check gives a single
// result carrying the error status.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data): writes the
// reference voltage; ready is always high. Write only while the block is idle.
// Flow: a valid anchor passes through the queue, the divider (difference over
// segment span) and a setup step (none for anchor 0), then gives one result
// per cycle while the receiver does not stall. An error request goes from the
// queue straight to its single result. The back end handles one request at a
// time and takes the next one from the queue once it is back in idle, after
// it has loaded the last result into the output register.
// Reset clears the reference, the anchor history, the queue and the output
// valid flag. While the receiver stalls, a held result stays and the sequencer
// waits to load the next; once the two-entry queue fills, o_in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module gamma_gray_level_interpolator #(
    parameter int NUM_COLORS = ggli_pkg::NUM_COLORS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [31:0]          i_cfg_data,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  ggli_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output ggli_pkg::t_out_item  o_out_result
);

    logic                 w_push;
    logic                 w_pop;
    ggli_pkg::t_cmd       w_push_cmd;
    ggli_pkg::t_cmd       w_pop_cmd;
    ggli_pkg::t_fifo_stat w_fifo_stat;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_fifo_stat.full;

    // Front: accepts and classifies requests, keeps the anchor history.
    ggli_front #(
        .NUM_COLORS (NUM_COLORS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .i_fifo_stat (w_fifo_stat),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    // Queue between the front and the back.
    ggli_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_pop_cmd),
        .o_stat  (w_fifo_stat)
    );

    // Back: divides once per segment and walks the gray levels.
    ggli_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_pop_cmd),
        .i_fifo_stat (w_fifo_stat),
        .o_pop       (w_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_result    (o_out_result)
    );

    // An error result is always the only, and so the final, result of its request.
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_result.status != ggli_pkg::STATUS_OK) |-> o_out_result.last)
        else $error("error result without last");

    // The front never pushes into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_fifo_stat.full)
        else $error("push into full queue");

    // The queue cannot report full and empty together.
    a_fifo_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_fifo_stat.full && w_fifo_stat.empty))
        else $error("queue full and empty");

    // Reset leaves no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire

// File: src/ggli_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ggli_front #(
    parameter int NUM_COLORS = ggli_pkg::NUM_COLORS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_valid,
    input  wire  [31:0]           i_cfg_data,
    input  wire                   i_in_valid,
    input  ggli_pkg::t_in_item    i_in_item,
    input  ggli_pkg::t_fifo_stat  i_fifo_stat,
    output logic                  o_push,
    output ggli_pkg::t_cmd        o_cmd
);

    localparam int IDX_W = (NUM_COLORS > 1) ? $clog2(NUM_COLORS) : 1;

    logic signed [31:0] r_ref;
    logic signed [31:0] r_prev [NUM_COLORS];

    logic               w_accept;
    logic               w_in_range;
    logic [IDX_W-1:0]   w_idx;
    logic signed [31:0] w_high;
    logic [32:0]        w_diff;
    logic [1:0]         w_status;

    // A request is taken whenever the queue has room.
    assign w_accept   = i_in_valid && !i_fifo_stat.full;
    assign w_in_range = (32'(i_in_item.anchor_number) < ggli_pkg::ANCHOR_COUNT) &&
                        (32'(i_in_item.color) < NUM_COLORS);
    assign w_idx      = i_in_item.color[IDX_W-1:0];

    // The top of the segment is the reference for the first anchor, else the
    // last anchor of this color that passed its check.
    always_comb begin
        if (i_in_item.anchor_number == 4'd0) begin
            w_high = r_ref;
        end else begin
            w_high = r_prev[w_idx];
        end
        w_diff = {w_high[31], w_high} - {i_in_item.anchor_voltage[31], i_in_item.anchor_voltage};
        if (r_ref <= 32'sd0) begin
            w_status = ggli_pkg::STATUS_REF_BAD;
        end else if (w_high <= i_in_item.anchor_voltage) begin
            w_status = ggli_pkg::STATUS_ANCHOR_BAD;
        end else begin
            w_status = ggli_pkg::STATUS_OK;
        end
    end

    // Out-of-range requests are dropped here and never reach the queue.
    assign o_push              = w_accept && w_in_range;
    assign o_cmd.color         = i_in_item.color;
    assign o_cmd.anchor_number = i_in_item.anchor_number;
    assign o_cmd.low           = i_in_item.anchor_voltage;
    assign o_cmd.diff          = w_diff[31:0];
    assign o_cmd.status        = w_status;

    // Reference register and per-color anchor history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= '0;
            for (int c = 0; c < NUM_COLORS; c++) begin
                r_prev[c] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_ref <= i_cfg_data;
            end
            for (int c = 0; c < NUM_COLORS; c++) begin
                if (o_push && (w_status == ggli_pkg::STATUS_OK) &&
                    (32'(i_in_item.color) == c)) begin
                    r_prev[c] <= i_in_item.anchor_voltage;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: src/ggli_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module ggli_fifo (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  ggli_pkg::t_cmd        i_cmd,
    input  wire                   i_pop,
    output ggli_pkg::t_cmd        o_cmd,
    output ggli_pkg::t_fifo_stat  o_stat
);

    localparam int DEPTH = ggli_pkg::FIFO_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ggli_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic w_do_push;
    logic w_do_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_do_push    = i_push && !o_stat.full;
    assign w_do_pop     = i_pop && !o_stat.empty;
    assign o_cmd        = r_mem[r_rd_ptr];

    // Pointer wrap at the queue depth.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (32'(p) == DEPTH - 1) begin
            n = '0;
        end else begin
            n = p + PTR_W'(1);
        end
        return n;
    endfunction

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (w_do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// File: src/ggli_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ggli_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  ggli_pkg::t_cmd        i_cmd,
    input  ggli_pkg::t_fifo_stat  i_fifo_stat,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire                   i_stall,
    output ggli_pkg::t_out_item   o_result
);

    localparam int CNT_W = $clog2(ggli_pkg::DIV_STEPS);

    ggli_pkg::t_state    r_state, n_state;
    ggli_pkg::t_cmd      r_cmd, n_cmd;
    logic [31:0]         r_dq, n_dq;
    logic [6:0]          r_rem, n_rem;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [31:0]         r_q, n_q;
    logic [6:0]          r_r, n_r;
    logic [7:0]          r_gray, n_gray;
    logic                r_out_valid, n_out_valid;
    ggli_pkg::t_out_item r_out, n_out;

    logic [7:0]  w_last_g;
    logic [7:0]  w_first_g;
    logic [7:0]  w_span8;
    logic [6:0]  w_span;
    logic        w_slot_free;
    logic [6:0]  w_partial;
    logic        w_ge;
    logic [7:0]  w_rdiff;
    logic [6:0]  w_step_r;
    logic [31:0] w_step_q;

    assign w_last_g    = ggli_pkg::anchor_last(r_cmd.anchor_number);
    assign w_first_g   = ggli_pkg::anchor_first(r_cmd.anchor_number);
    assign w_span8     = w_last_g - w_first_g;
    assign w_span      = w_span8[6:0];
    assign w_slot_free = !r_out_valid || !i_stall;

    // One restoring division step of the difference by the segment span.
    assign w_partial = {r_rem[5:0], r_dq[31]};
    assign w_ge      = (w_partial >= w_span);

    // Moving one gray level up removes diff/span from the running quotient:
    // subtract the whole part and the remainder, borrowing one on underflow.
    always_comb begin
        w_rdiff = {1'b0, r_r} - {1'b0, r_rem};
        if (w_rdiff[7]) begin
            w_step_r = w_rdiff[6:0] + w_span;
            w_step_q = r_q - r_dq - 32'd1;
        end else begin
            w_step_r = w_rdiff[6:0];
            w_step_q = r_q - r_dq;
        end
    end

    // Sequencer: next state, datapath updates and result loading.
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_dq        = r_dq;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_q         = r_q;
        n_r         = r_r;
        n_gray      = r_gray;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        o_pop       = 1'b0;
        case (r_state)
            ggli_pkg::ST_IDLE: begin
                if (!i_fifo_stat.empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    n_dq  = i_cmd.diff;
                    n_rem = '0;
                    n_cnt = '0;
                    if (i_cmd.status != ggli_pkg::STATUS_OK) begin
                        n_state = ggli_pkg::ST_ERR;
                    end else begin
                        n_state = ggli_pkg::ST_DIV;
                    end
                end
            end
            ggli_pkg::ST_DIV: begin
                n_rem = w_ge ? (w_partial - w_span) : w_partial;
                n_dq  = {r_dq[30:0], w_ge};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(ggli_pkg::DIV_STEPS - 1)) begin
                    // Start at the segment top, where the quotient is the full difference.
                    n_q    = r_cmd.diff;
                    n_r    = '0;
                    n_gray = w_first_g;
                    if (r_cmd.anchor_number == 4'd0) begin
                        n_state = ggli_pkg::ST_EMIT;
                    end else begin
                        n_state = ggli_pkg::ST_ADV;
                    end
                end
            end
            ggli_pkg::ST_ADV: begin
                // The previous anchor's own level is not part of this segment.
                n_q     = w_step_q;
                n_r     = w_step_r;
                n_gray  = r_gray + 8'd1;
                n_state = ggli_pkg::ST_EMIT;
            end
            ggli_pkg::ST_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid         = 1'b1;
                    n_out.gray_level    = r_gray;
                    n_out.out_color     = r_cmd.color;
                    n_out.level_voltage = r_cmd.low + r_q;
                    n_out.status        = ggli_pkg::STATUS_OK;
                    n_out.last          = (r_gray == w_last_g);
                    n_q                 = w_step_q;
                    n_r                 = w_step_r;
                    n_gray              = r_gray + 8'd1;
                    if (r_gray == w_last_g) begin
                        n_state = ggli_pkg::ST_IDLE;
                    end
                end
            end
            ggli_pkg::ST_ERR: begin
                if (w_slot_free) begin
                    n_out_valid         = 1'b1;
                    n_out.gray_level    = w_last_g;
                    n_out.out_color     = r_cmd.color;
                    n_out.level_voltage = '0;
                    n_out.status        = r_cmd.status;
                    n_out.last          = 1'b1;
                    n_state             = ggli_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ggli_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ggli_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_dq   <= n_dq;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_q    <= n_q;
        r_r    <= n_r;
        r_gray <= n_gray;
        r_out  <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_CH      = 3;
    localparam int IDLE_WAIT   = 150;
    localparam int STUCK_LIMIT = 5000;
    localparam int HOLD_AFTER  = 1500;
    localparam int HOLD_CYCLES = 600;
    localparam logic signed [31:0] V_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] V_MIN = 32'sh8000_0000;

    // Gray level of each anchor, anchor 0 in the low byte.
    localparam logic [ggli_pkg::ANCHOR_COUNT-1:0][7:0] GRAY_AT =
        {8'd255, 8'd203, 8'd151, 8'd87, 8'd51, 8'd35, 8'd23, 8'd11, 8'd3};

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [31:0]         i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    ggli_pkg::t_in_item  i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    ggli_pkg::t_out_item o_out_result;

    // Mirror of the block state, updated as requests are accepted.
    logic signed [31:0] ref_level;
    logic signed [31:0] last_anchor_v [NUM_CH];

    ggli_pkg::t_in_item  anchor_q [$];
    ggli_pkg::t_out_item level_q [$];

    int n_queued     = 0;
    int n_taken      = 0;
    int n_checked    = 0;
    int n_errors     = 0;
    int send_gap     = 0;
    int stall_left   = 0;
    int stuck_cycles = 0;
    bit hold_done    = 1'b0;

    gamma_gray_level_interpolator #(
        .NUM_COLORS(NUM_CH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_result(o_out_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic ggli_pkg::t_out_item level_result(logic [7:0] gray, logic [1:0] color,
                                                         logic [31:0] volt,
                                                         logic [1:0] status, logic last);
        ggli_pkg::t_out_item r;
        r.gray_level    = gray;
        r.out_color     = color;
        r.level_voltage = volt;
        r.status        = status;
        r.last          = last;
        return r;
    endfunction

    // Idle length for either side: mostly none, some short, a few long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(15, 40);
    endfunction

    // Work out the gray-level voltages of the segment ending at this anchor.
    task automatic predict_segment(input ggli_pkg::t_in_item req);
        logic [7:0] g_end, g_start;
        longint     v_top, v_low, span, steps_down, v;
        int         g;
        if (req.anchor_number >= ggli_pkg::ANCHOR_COUNT || req.color >= NUM_CH) return;
        g_end   = GRAY_AT[req.anchor_number];
        g_start = (req.anchor_number == 0) ? 8'd0 : GRAY_AT[req.anchor_number - 1];
        v_low   = longint'($signed(req.anchor_voltage));
        v_top   = (req.anchor_number == 0) ? longint'(ref_level)
                                           : longint'(last_anchor_v[req.color]);
        if (ref_level <= 0) begin
            level_q.push_back(level_result(g_end, req.color, '0,
                                           ggli_pkg::STATUS_REF_BAD, 1'b1));
        end else if (v_top <= v_low) begin
            level_q.push_back(level_result(g_end, req.color, '0,
                                           ggli_pkg::STATUS_ANCHOR_BAD, 1'b1));
        end else begin
            span = longint'(g_end) - longint'(g_start);
            // Anchor 0 also covers gray 0, which sits at the reference.
            if (req.anchor_number == 0) begin
                level_q.push_back(level_result(8'd0, req.color, v_top[31:0],
                                               ggli_pkg::STATUS_OK, 1'b0));
            end
            for (g = g_start + 1; g < g_end; g++) begin
                steps_down = longint'(g_end) - g;
                v          = v_low + ((v_top - v_low) * steps_down) / span;
                level_q.push_back(level_result(g[7:0], req.color, v[31:0],
                                               ggli_pkg::STATUS_OK, 1'b0));
            end
            level_q.push_back(level_result(g_end, req.color, req.anchor_voltage,
                                           ggli_pkg::STATUS_OK, 1'b1));
            last_anchor_v[req.color] = req.anchor_voltage;
        end
    endtask

    task automatic queue_anchor(input int color, input int num, input logic [31:0] volt);
        ggli_pkg::t_in_item it;
        it.color          = color[1:0];
        it.anchor_number  = num[3:0];
        it.anchor_voltage = volt;
        anchor_q.push_back(it);
        n_queued++;
    endtask

    // Write the reference voltage; only called while the block is idle.
    task automatic write_reference(input logic signed [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        ref_level = value;
    endtask

    // Wait until every request is taken and answered, then let the block drain.
    task automatic settle();
        while (n_taken != n_queued) @(posedge i_clk);
        @(posedge i_clk);
        while (level_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    // Mostly descending anchor sets per color, with restarts, skips and noise.
    task automatic random_anchors(input int count);
        int     made, c, num, pick, steps_left;
        int     next_num [NUM_CH];
        longint gen_last [NUM_CH];
        longint top, room, delta, v;
        for (c = 0; c < NUM_CH; c++) begin
            next_num[c] = 0;
            gen_last[c] = longint'(last_anchor_v[c]);
        end
        made = 0;
        while (made < count) begin
            c    = $urandom_range(0, NUM_CH - 1);
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                // Any field value at all.
                num = $urandom_range(0, 15);
                top = $urandom_range(0, 3);
                queue_anchor(int'(top), num, $urandom);
                if (top < NUM_CH && num < ggli_pkg::ANCHOR_COUNT) made++;
            end else if (pick < 10) begin
                // Requests the block drops.
                if ($urandom_range(0, 1)) queue_anchor(3, $urandom_range(0, 8), $urandom);
                else queue_anchor(c, $urandom_range(9, 15), $urandom);
            end else if (pick < 18) begin
                // Anchor at or above the voltage it must stay under.
                num = $urandom_range(0, 8);
                top = (num == 0) ? longint'(ref_level) : gen_last[c];
                v   = top + longint'($urandom_range(0, 65535));
                if (v > V_MAX) v = V_MAX;
                queue_anchor(c, num, v[31:0]);
                made++;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 5) next_num[c] = 0;
                else if (pick < 10) next_num[c] = $urandom_range(1, 8);
                num        = next_num[c];
                top        = (num == 0) ? longint'(ref_level) : gen_last[c];
                steps_left = ggli_pkg::ANCHOR_COUNT - num;
                room       = top - longint'(V_MIN);
                case ($urandom_range(0, 3))
                    0: begin
                        delta = 1;
                    end
                    1: begin
                        delta = longint'($urandom_range(1, 5000));
                    end
                    default: begin
                        delta = 1 + ((room / steps_left) *
                                     longint'($urandom_range(0, 1023))) / 1024;
                    end
                endcase
                if (delta > room) delta = room;
                v = top - delta;
                queue_anchor(c, num, v[31:0]);
                if (v < top && ref_level > 0) gen_last[c] = v;
                next_num[c] = (num == 8) ? 0 : num + 1;
                made++;
            end
        end
    endtask

    // Request driver: offers queued anchors with random gaps after each one taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_segment(i_in_item);
                n_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap   <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (anchor_q.size() > 0) begin
                    i_in_item  <= anchor_q.pop_front();
                    i_in_valid <= 1'b1;
                    send_gap   <= idle_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_result(input ggli_pkg::t_out_item got);
        ggli_pkg::t_out_item want;
        if (level_q.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) begin
                $display("unexpected result: gray %0d color %0d voltage %0d %s %0d last %0d",
                         got.gray_level, got.out_color, $signed(got.level_voltage),
                         "status", got.status, got.last);
            end
            return;
        end
        want = level_q.pop_front();
        n_checked++;
        if (got.gray_level !== want.gray_level || got.out_color !== want.out_color ||
            got.level_voltage !== want.level_voltage || got.status !== want.status ||
            got.last !== want.last) begin
            n_errors++;
            if (n_errors <= 10) begin
                $display("result %0d mismatch: expected gray %0d color %0d voltage %0d",
                         n_checked, want.gray_level, want.out_color,
                         $signed(want.level_voltage));
                $display("  expected status %0d last %0d", want.status, want.last);
                $display("  got gray %0d color %0d voltage %0d status %0d last %0d",
                         got.gray_level, got.out_color, $signed(got.level_voltage),
                         got.status, got.last);
            end
        end
    endtask

    // Result monitor and receiver stall, with one long hold-off to fill the block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) check_result(o_out_result);
            if (!hold_done && n_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if (i_out_stall) begin
                stall_left = $urandom_range(0, 40);
                i_out_stall <= 1'b0;
            end else begin
                stall_left = idle_len();
                i_out_stall <= (stall_left > 0);
            end
        end
    end

    // Watchdog: too long with no handshake on any channel ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        int k;
        ref_level = '0;
        for (k = 0; k < NUM_CH; k++) last_anchor_v[k] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reference still at its reset value of zero.
        queue_anchor(2, 0, V_MIN);
        queue_anchor(0, 8, V_MAX);
        queue_anchor(3, 9, 32'd5);
        settle();

        // Largest reference: a full descending set and the single-result cases.
        write_reference(V_MAX);
        queue_anchor(0, 0, V_MAX - 1);
        queue_anchor(0, 1, 32'd1_000_000_000);
        queue_anchor(0, 2, 32'd500_000_000);
        queue_anchor(0, 3, 32'd100);
        queue_anchor(0, 4, 32'd0);
        queue_anchor(0, 5, -32'sd1);
        queue_anchor(0, 6, -32'sd1000);
        queue_anchor(0, 7, -32'sd2_000_000_000);
        queue_anchor(0, 8, V_MIN);
        // Anchors out of order take the last voltage of the color that passed its check.
        queue_anchor(2, 5, -32'sd100);
        queue_anchor(2, 2, -32'sd200);
        // Widest possible difference, then an equal voltage.
        queue_anchor(2, 0, V_MIN);
        queue_anchor(2, 1, V_MIN);
        // Anchor equal to the reference, and equal to the previous anchor.
        queue_anchor(1, 0, V_MAX);
        queue_anchor(1, 4, 32'd0);
        // Unbuilt color and anchor number past the table.
        queue_anchor(3, 2, 32'd7);
        queue_anchor(1, 15, 32'hFFFF_FFFF);
        settle();

        // Smallest positive reference.
        write_reference(32'sd1);
        queue_anchor(1, 0, 32'd0);
        queue_anchor(0, 0, 32'd1);
        settle();

        // Most negative reference.
        write_reference(V_MIN);
        queue_anchor(0, 3, -32'sd5);
        queue_anchor(1, 0, V_MIN);
        settle();

        write_reference(V_MAX);
        random_anchors(60);
        settle();
        write_reference(32'sd1000);
        random_anchors(45);
        settle();
        write_reference($urandom_range(1, 32'h7FFF_FFFF));
        random_anchors(60);
        settle();
        write_reference({1'b1, 31'($urandom)});
        random_anchors(6);
        settle();
        write_reference($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
        random_anchors(65);
        settle();

        if (n_errors == 0 && level_q.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
